[src/mts_pkg.sv]
// Package with the shared types and constants of the min tracking stack.
`timescale 1ns / 1ps
package mts_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]              count_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic   operation;
    value_t push_value;
  } in_word_t;

  typedef struct packed {
    status_t status;
    value_t  popped_value;
    value_t  top_value;
    value_t  min_value;
    logic    not_empty;
  } out_word_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

[src/mts_cell.sv]
// One stack cell that takes its neighbor's entry on a push or a pop.
`timescale 1ns / 1ps
module mts_cell (
  input  logic               clk,
  input  mts_pkg::shift_ctl_t ctl,
  input  mts_pkg::value_t    above,
  input  mts_pkg::value_t    below,
  output mts_pkg::value_t    q
);
  import mts_pkg::*;

  value_t data_r;
  value_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.push) begin
      data_nxt = above;
    end else if (ctl.pop) begin
      data_nxt = below;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

[src/mts_lane.sv]
// Row of stack cells with the top entry in cell zero.
`timescale 1ns / 1ps
module mts_lane (
  input  logic                clk,
  input  mts_pkg::shift_ctl_t ctl,
  input  mts_pkg::value_t     din,
  output mts_pkg::value_t     head0,
  output mts_pkg::value_t     head1
);
  import mts_pkg::*;

  value_t cell_q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    value_t above;
    value_t below;
    if (i == 0) begin : g_first
      assign above = din;
    end else begin : g_mid_a
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = cell_q[i];
    end else begin : g_mid_b
      assign below = cell_q[i+1];
    end
    mts_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above),
      .below (below),
      .q     (cell_q[i])
    );
  end

  assign head0 = cell_q[0];
  assign head1 = cell_q[1];

endmodule

[src/min_tracking_stack_top.sv]
// Top level of the min tracking stack with its count and result logic.
//
//   channel | direction | ports                          | word type
//   in      | input     | in_valid, in_ready, in_word    | in_word_t
//   out     | output    | out_valid, out_ready, out_word | out_word_t
//
// A word can be accepted in every cycle the output is not stalled. Push and pop
// shift every value cell at once, and every min cell when the minimum changes,
// so top entries sit in cell zero and the result comes from compares on them.
// Reset clears the counts and the output valid; the cells are not reset.
// A stalled output holds its word; a new word is taken in the cycle it drains.
`timescale 1ns / 1ps
module min_tracking_stack_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mts_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output mts_pkg::out_word_t out_word
);
  import mts_pkg::*;

  localparam count_t FULL_CNT = count_t'(STACK_DEPTH);
  localparam count_t ONE_CNT  = count_t'(1);

  count_t     value_cnt_r;
  count_t     value_cnt_nxt;
  count_t     min_cnt_r;
  count_t     min_cnt_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_word_t  out_word_r;
  out_word_t  out_word_nxt;
  shift_ctl_t value_ctl;
  shift_ctl_t min_ctl;
  value_t     top0;
  value_t     top1;
  value_t     min0;
  value_t     min1;
  value_t     v;
  logic       accept;
  logic       is_pop;
  logic       min_push;
  logic       min_pop;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign v        = in_word.push_value;
  assign is_pop   = (op_t'(in_word.operation) == OP_POP);

  mts_lane u_value_lane (
    .clk   (clk),
    .ctl   (value_ctl),
    .din   (v),
    .head0 (top0),
    .head1 (top1)
  );

  mts_lane u_min_lane (
    .clk   (clk),
    .ctl   (min_ctl),
    .din   (v),
    .head0 (min0),
    .head1 (min1)
  );

  always_comb begin
    value_ctl     = '0;
    min_ctl       = '0;
    min_push      = 1'b0;
    min_pop       = 1'b0;
    value_cnt_nxt = value_cnt_r;
    min_cnt_nxt   = min_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    if (accept) begin
      out_valid_nxt          = 1'b1;
      out_word_nxt           = '0;
      out_word_nxt.status    = ST_OK;
      if (!is_pop) begin
        if (value_cnt_r == FULL_CNT) begin
          out_word_nxt.status    = ST_FULL;
          out_word_nxt.top_value = top0;
          out_word_nxt.min_value = min0;
          out_word_nxt.not_empty = 1'b1;
        end else begin
          min_push       = ((value_cnt_r == '0) || (v <= min0)) && (min_cnt_r != FULL_CNT);
          value_ctl.push = 1'b1;
          min_ctl.push   = min_push;
          value_cnt_nxt  = value_cnt_r + ONE_CNT;
          if (min_push) begin
            min_cnt_nxt = min_cnt_r + ONE_CNT;
          end
          out_word_nxt.top_value = v;
          out_word_nxt.min_value = min_push ? v : min0;
          out_word_nxt.not_empty = 1'b1;
        end
      end else begin
        if (value_cnt_r == '0) begin
          out_word_nxt.status = ST_EMPTY;
        end else begin
          min_pop       = (min_cnt_r != '0) && (top0 == min0);
          value_ctl.pop = 1'b1;
          min_ctl.pop   = min_pop;
          value_cnt_nxt = value_cnt_r - ONE_CNT;
          if (min_pop) begin
            min_cnt_nxt = min_cnt_r - ONE_CNT;
          end
          out_word_nxt.popped_value = top0;
          if (value_cnt_r != ONE_CNT) begin
            out_word_nxt.top_value = top1;
            out_word_nxt.min_value = min_pop ? min1 : min0;
            out_word_nxt.not_empty = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_cnt_r <= '0;
      min_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      value_cnt_r <= value_cnt_nxt;
      min_cnt_r   <= min_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[src/mts_checker.sv]
// Port checker for the min tracking stack and its bind to the top level.
`timescale 1ns / 1ps
module mts_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input mts_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_ready,
  input mts_pkg::out_word_t out_word
);
  import mts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("Stalled output word changed.");

  a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (op_t'(in_word.operation) == OP_PUSH) |=>
      out_valid && ((out_word.status == ST_FULL) ||
                    (out_word.top_value == $past(in_word.push_value))))
    else $error("Accepted push did not show its value on top.");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.not_empty |->
      (out_word.top_value == '0) && (out_word.min_value == '0))
    else $error("Empty stack reported a nonzero top or minimum.");

  a_reject_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == ST_EMPTY) |->
      !out_word.not_empty && (out_word.popped_value == '0))
    else $error("Rejected pop reported data.");

  a_min_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.not_empty |-> (out_word.min_value <= out_word.top_value))
    else $error("Reported minimum exceeds the top value.");

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (.*);

[sim/min_stack_checker.sv]
// Checker that predicts every min tracking stack result and compares it with the block's output.
`timescale 1ns / 1ps
module min_stack_checker
  import mts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_word,
  output int unsigned words_pending,
  output int unsigned mismatch_count
);

  value_t    value_row [STACK_DEPTH];
  value_t    min_row   [STACK_DEPTH];
  int        value_depth;
  int        min_depth;
  out_word_t pending_results [$];

  initial begin
    words_pending  = 0;
    mismatch_count = 0;
    value_depth    = 0;
    min_depth      = 0;
  end

  function automatic out_word_t step_stack(in_word_t w);
    out_word_t r;
    value_t    v;
    logic      new_min;
    r        = '0;
    r.status = ST_OK;
    v        = w.push_value;
    if (w.operation == OP_PUSH) begin
      if (value_depth >= STACK_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        new_min = (value_depth == 0);
        if (!new_min) new_min = (v <= min_row[min_depth-1]);
        if (new_min && min_depth < STACK_DEPTH) begin
          min_row[min_depth] = v;
          min_depth++;
        end
        value_row[value_depth] = v;
        value_depth++;
      end
    end else begin
      if (value_depth == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped_value = value_row[value_depth-1];
        value_depth--;
        if (min_depth != 0 && r.popped_value == min_row[min_depth-1]) min_depth--;
      end
    end
    if (value_depth != 0) begin
      r.top_value = value_row[value_depth-1];
      r.min_value = min_row[min_depth-1];
      r.not_empty = 1'b1;
    end
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      pending_results.delete();
      value_depth = 0;
      min_depth   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected output word %h", $realtime, out_word);
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 32'(want.status), 32'(out_word.status));
          compare_field("popped_value", want.popped_value, out_word.popped_value);
          compare_field("top_value", want.top_value, out_word.top_value);
          compare_field("min_value", want.min_value, out_word.min_value);
          compare_field("not_empty", 32'(want.not_empty), 32'(out_word.not_empty));
        end
      end
      if (in_valid && in_ready) pending_results.push_back(step_stack(in_word));
    end
    words_pending = pending_results.size();
  end

endmodule

[sim/tb_min_tracking_stack_top.sv]
// Testbench top that drives the min tracking stack and reports the verdict.
`timescale 1ns / 1ps
module tb_min_tracking_stack_top;
  import mts_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 212;
  localparam int SRC_IDLE_PCT [4] = '{0, 53, 0, 37};
  localparam int DST_STALL_PCT [4] = '{0, 0, 53, 37};
  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  int unsigned words_pending;
  int unsigned mismatch_count;
  int          src_idle_pct = 0;
  int          dst_stall_pct = 0;
  int          stack_fill = 0;
  int unsigned cycle_count = 0;

  min_tracking_stack_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  min_stack_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .words_pending  (words_pending),
    .mismatch_count (mismatch_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= dst_stall_pct);
  end

  task automatic send_word(logic operation, value_t push_value);
    in_word_t w;
    w.operation  = operation;
    w.push_value = push_value;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (operation == OP_PUSH && stack_fill < STACK_DEPTH) stack_fill++;
    if (operation == OP_POP && stack_fill > 0) stack_fill--;
    @(negedge clk);
  endtask

  function automatic value_t random_value();
    case ($urandom_range(9))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2, 3, 4: return value_t'($signed($urandom_range(6)) - 3);
      default: return value_t'($urandom);
    endcase
  endfunction

  initial begin
    logic filling;
    logic want_push;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(OP_POP, value_t'($urandom));
    send_word(OP_PUSH, '0);
    send_word(OP_PUSH, VALUE_MAX);
    send_word(OP_PUSH, VALUE_MIN);
    send_word(OP_PUSH, VALUE_MIN);
    send_word(OP_PUSH, VALUE_MAX);
    repeat (3) send_word(OP_POP, value_t'($urandom));
    send_word(OP_PUSH, -1);
    send_word(OP_PUSH, -1);
    send_word(OP_PUSH, '0);
    repeat (6) send_word(OP_POP, value_t'($urandom));

    filling = 1'b1;
    for (int m = 0; m < 4; m++) begin
      src_idle_pct  = SRC_IDLE_PCT[m];
      dst_stall_pct = DST_STALL_PCT[m];
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        if (filling && stack_fill == STACK_DEPTH && $urandom_range(99) < 30) filling = 1'b0;
        else if (!filling && stack_fill == 0 && $urandom_range(99) < 30) filling = 1'b1;
        want_push = (($urandom_range(99) < 85) == filling);
        send_word(want_push ? OP_PUSH : OP_POP, random_value());
      end
    end

    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
